// File: rtl/core/alx_pkg.sv
package alx_pkg;

   localparam int TOK_W = 16;
   localparam int VALUE_W = 31;
   localparam int LIMIT_W = 16;
   localparam int CH_W = 8;
   localparam int KIND_W = 4;

   localparam logic [VALUE_W-1:0] VALUE_MAX = {VALUE_W{1'b1}};
   localparam logic [LIMIT_W-1:0] LIMIT_RESET = {LIMIT_W{1'b1}};

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam int QUEUE_ROOM = 2;

   localparam logic [CH_W-1:0] CH_END = 8'h00;
   localparam logic [CH_W-1:0] CH_SPACE = " ";
   localparam logic [CH_W-1:0] CH_TAB = 8'h09;
   localparam logic [CH_W-1:0] CH_CR = 8'h0D;
   localparam logic [CH_W-1:0] CH_LF = 8'h0A;
   localparam logic [CH_W-1:0] CH_UNDERSCORE = "_";
   localparam logic [CH_W-1:0] CH_ZERO = "0";
   localparam logic [CH_W-1:0] CH_NINE = "9";
   localparam logic [CH_W-1:0] CH_LOWER_A = "a";
   localparam logic [CH_W-1:0] CH_LOWER_Z = "z";
   localparam logic [CH_W-1:0] CH_UPPER_A = "A";
   localparam logic [CH_W-1:0] CH_UPPER_Z = "Z";
   localparam logic [CH_W-1:0] CH_PLUS = "+";
   localparam logic [CH_W-1:0] CH_MINUS = "-";
   localparam logic [CH_W-1:0] CH_STAR = "*";
   localparam logic [CH_W-1:0] CH_SLASH = "/";
   localparam logic [CH_W-1:0] CH_LPAREN = "(";
   localparam logic [CH_W-1:0] CH_RPAREN = ")";

   typedef enum logic [KIND_W-1:0] {
      KIND_EOF     = 4'd0,
      KIND_NUMBER  = 4'd1,
      KIND_IDENT   = 4'd2,
      KIND_PLUS    = 4'd3,
      KIND_MINUS   = 4'd4,
      KIND_STAR    = 4'd5,
      KIND_SLASH   = 4'd6,
      KIND_LPAREN  = 4'd7,
      KIND_RPAREN  = 4'd8,
      KIND_UNKNOWN = 4'd9
   } tok_kind_type;

   typedef enum logic [1:0] {
      RUN_NONE = 2'd0,
      RUN_NUM  = 2'd1,
      RUN_ID   = 2'd2
   } run_kind_type;

   typedef struct packed {
      tok_kind_type        kind;
      logic [VALUE_W-1:0]  value;
      logic [TOK_W-1:0]    start;
      logic [TOK_W-1:0]    length;
      logic                overflow;
      logic                last;
   } token_type;

   typedef struct packed {
      logic [1:0] count;
      token_type  first;
      token_type  second;
   } push_type;

endpackage

// File: rtl/core/alx_if.sv
interface alx_req_if;
   import alx_pkg::*;
   logic            valid;
   logic            ready;
   logic [CH_W-1:0] ch;
   modport source (output valid, output ch, input ready);
   modport sink (input valid, input ch, output ready);
endinterface

interface alx_rsp_if;
   import alx_pkg::*;
   logic               valid;
   logic               ready;
   logic [KIND_W-1:0]  tok_kind;
   logic [VALUE_W-1:0] tok_value;
   logic [TOK_W-1:0]   tok_start;
   logic [TOK_W-1:0]   tok_length;
   logic               value_overflow;
   logic               last;
   modport source (output valid, output tok_kind, output tok_value, output tok_start,
                   output tok_length, output value_overflow, output last, input ready);
   modport sink (input valid, input tok_kind, input tok_value, input tok_start,
                 input tok_length, input value_overflow, input last, output ready);
endinterface

interface alx_csr_if;
   import alx_pkg::*;
   logic               valid;
   logic               ready;
   logic [LIMIT_W-1:0] token_limit;
   modport source (output valid, output token_limit, input ready);
   modport sink (input valid, input token_limit, output ready);
endinterface

// File: rtl/core/alx_front.sv
module alx_front #(
   parameter int POS_BITS = 16
) (
   input  logic              clock,
   input  logic              reset,
   alx_req_if.sink           req,
   alx_csr_if.sink           csr,
   input  logic              room_ok,
   output alx_pkg::push_type push
);
   import alx_pkg::*;

   localparam int LowBits = (POS_BITS < TOK_W) ? POS_BITS : TOK_W;

   run_kind_type         run_kind_ff, run_kind_in;
   logic [VALUE_W-1:0]   run_value_ff, run_value_in;
   logic                 run_ovf_ff, run_ovf_in;
   logic [POS_BITS-1:0]  run_start_ff, run_start_in;
   logic [POS_BITS-1:0]  pos_ff, pos_in;
   logic [LIMIT_W-1:0]   emitted_ff, emitted_in;
   logic                 stopped_ff, stopped_in;
   logic [LIMIT_W-1:0]   limit_ff;

   logic [CH_W-1:0]      c;
   logic                 fire;
   logic                 is_end, is_digit, is_id, is_space;
   logic                 cont_num, cont_id, want_close, want_second;
   logic [VALUE_W+3:0]   num_prod;
   logic                 num_ovf;
   logic [POS_BITS-1:0]  run_len;
   tok_kind_type         op_kind, kind2;
   logic                 allow1, allow2, last1, last2, stop1, stop2;
   logic [LIMIT_W-1:0]   cnt1, cnt2;
   token_type            tok_close, tok_second;

   assign c = req.ch;
   assign req.ready = room_ok;
   assign fire = req.valid && room_ok;
   assign csr.ready = 1'b1;

   always_comb begin
      is_end = (c == CH_END);
      is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
      is_id = ((c >= CH_LOWER_A) && (c <= CH_LOWER_Z)) ||
              ((c >= CH_UPPER_A) && (c <= CH_UPPER_Z)) || (c == CH_UNDERSCORE);
      is_space = (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
      case (c)
         CH_PLUS:   op_kind = KIND_PLUS;
         CH_MINUS:  op_kind = KIND_MINUS;
         CH_STAR:   op_kind = KIND_STAR;
         CH_SLASH:  op_kind = KIND_SLASH;
         CH_LPAREN: op_kind = KIND_LPAREN;
         CH_RPAREN: op_kind = KIND_RPAREN;
         default:   op_kind = KIND_UNKNOWN;
      endcase
   end

   always_comb begin
      cont_num = !is_end && (run_kind_ff == RUN_NUM) && is_digit;
      cont_id = !is_end && (run_kind_ff == RUN_ID) && (is_id || is_digit);
      want_close = !cont_num && !cont_id && (run_kind_ff != RUN_NONE);
      want_second = is_end || (!cont_num && !cont_id && !is_space && !is_digit && !is_id);
      kind2 = is_end ? KIND_EOF : op_kind;

      num_prod = ({4'd0, run_value_ff} << 3) + ({4'd0, run_value_ff} << 1) +
                 (VALUE_W+4)'(c[3:0]);
      num_ovf = run_ovf_ff || (num_prod > (VALUE_W+4)'(VALUE_MAX));
      run_len = pos_ff - run_start_ff;

      allow1 = want_close && !stopped_ff && (emitted_ff < limit_ff);
      cnt1 = allow1 ? emitted_ff + LIMIT_W'(1) : emitted_ff;
      last1 = (cnt1 >= limit_ff);
      stop1 = stopped_ff || (allow1 && last1);
      allow2 = want_second && !stop1 && (cnt1 < limit_ff);
      cnt2 = allow2 ? cnt1 + LIMIT_W'(1) : cnt1;
      last2 = (kind2 == KIND_EOF) || (cnt2 >= limit_ff);
      stop2 = stop1 || (allow2 && last2);

      tok_close.kind = (run_kind_ff == RUN_NUM) ? KIND_NUMBER : KIND_IDENT;
      tok_close.value = (run_kind_ff == RUN_NUM) ? run_value_ff : '0;
      tok_close.start = TOK_W'(run_start_ff[LowBits-1:0]);
      tok_close.length = TOK_W'(run_len[LowBits-1:0]);
      tok_close.overflow = (run_kind_ff == RUN_NUM) && run_ovf_ff;
      tok_close.last = last1;

      tok_second.kind = kind2;
      tok_second.value = '0;
      tok_second.start = TOK_W'(pos_ff[LowBits-1:0]);
      tok_second.length = is_end ? '0 : TOK_W'(1);
      tok_second.overflow = 1'b0;
      tok_second.last = last2;

      push.count = fire ? ({1'b0, allow1} + {1'b0, allow2}) : 2'd0;
      push.first = allow1 ? tok_close : tok_second;
      push.second = tok_second;
   end

   always_comb begin
      run_kind_in = run_kind_ff;
      run_value_in = run_value_ff;
      run_ovf_in = run_ovf_ff;
      run_start_in = run_start_ff;
      pos_in = pos_ff;
      emitted_in = emitted_ff;
      stopped_in = stopped_ff;
      if (fire) begin
         if (is_end) begin
            run_kind_in = RUN_NONE;
            run_value_in = '0;
            run_ovf_in = 1'b0;
            run_start_in = '0;
            pos_in = '0;
            emitted_in = '0;
            stopped_in = 1'b0;
         end else begin
            emitted_in = cnt2;
            stopped_in = stop2;
            pos_in = pos_ff + POS_BITS'(1);
            if (cont_num) begin
               run_value_in = num_ovf ? VALUE_MAX : num_prod[VALUE_W-1:0];
               run_ovf_in = num_ovf;
            end else if (!cont_id) begin
               run_kind_in = RUN_NONE;
               run_value_in = '0;
               run_ovf_in = 1'b0;
               if (is_digit) begin
                  run_kind_in = RUN_NUM;
                  run_start_in = pos_ff;
                  run_value_in = VALUE_W'(c[3:0]);
               end else if (is_id) begin
                  run_kind_in = RUN_ID;
                  run_start_in = pos_ff;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_kind_ff <= RUN_NONE;
         run_value_ff <= '0;
         run_ovf_ff <= 1'b0;
         run_start_ff <= '0;
         pos_ff <= '0;
         emitted_ff <= '0;
         stopped_ff <= 1'b0;
         limit_ff <= LIMIT_RESET;
      end else begin
         run_kind_ff <= run_kind_in;
         run_value_ff <= run_value_in;
         run_ovf_ff <= run_ovf_in;
         run_start_ff <= run_start_in;
         pos_ff <= pos_in;
         emitted_ff <= emitted_in;
         stopped_ff <= stopped_in;
         if (csr.valid) begin
            limit_ff <= csr.token_limit;
         end
      end
   end

endmodule

// File: rtl/core/alx_tokq.sv
module alx_tokq (
   input  logic               clock,
   input  logic               reset,
   input  alx_pkg::push_type  push,
   output logic               room_ok,
   input  logic               pop,
   output logic               head_valid,
   output alx_pkg::token_type head
);
   import alx_pkg::*;

   token_type          mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  head_ff, head_in;
   logic [QPTR_W-1:0]  tail_ff, tail_in;
   logic [QCNT_W-1:0]  count_ff, count_in;
   logic               do_pop;
   logic [QPTR_W-1:0]  tail_next;

   assign room_ok = (count_ff <= QCNT_W'(QUEUE_DEPTH - QUEUE_ROOM));
   assign head_valid = (count_ff != '0);
   assign head = mem_ff[head_ff];
   assign do_pop = pop && head_valid;
   assign tail_next = tail_ff + QPTR_W'(1);

   always_comb begin
      head_in = do_pop ? head_ff + QPTR_W'(1) : head_ff;
      tail_in = tail_ff + QPTR_W'(push.count);
      count_in = count_ff + QCNT_W'(push.count) - QCNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem_ff[tail_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         mem_ff[tail_next] <= push.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff <= '0;
         tail_ff <= '0;
         count_ff <= '0;
      end else begin
         head_ff <= head_in;
         tail_ff <= tail_in;
         count_ff <= count_in;
      end
   end

endmodule

// File: rtl/core/alx_back.sv
module alx_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               head_valid,
   input  alx_pkg::token_type head,
   output logic               pop,
   alx_rsp_if.source          rsp
);
   import alx_pkg::*;

   token_type out_ff, out_in;
   logic      valid_ff, valid_in;
   logic      take;

   assign take = !valid_ff || rsp.ready;
   assign pop = take && head_valid;

   always_comb begin
      valid_in = take ? head_valid : valid_ff;
      out_in = pop ? head : out_ff;
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign rsp.valid = valid_ff;
   assign rsp.tok_kind = out_ff.kind;
   assign rsp.tok_value = out_ff.value;
   assign rsp.tok_start = out_ff.start;
   assign rsp.tok_length = out_ff.length;
   assign rsp.value_overflow = out_ff.overflow;
   assign rsp.last = out_ff.last;

endmodule

// File: rtl/core/arith_expression_lexer.sv
// Channel  Direction  Transaction
// req_bus  in         one source byte (ch); zero ends the text
// rsp_bus  out        one token: kind, value, start, length, overflow, last
// csr_bus  in         token_limit write, always ready
//
// Takes one byte per cycle unless req_bus stalls; a byte that closes a run and
// also yields an operator or eof token puts two tokens into a 4-entry queue.
// Tokens go via the queue and output register; rsp_bus drains one per ready cycle.
// req_bus stalls only while the queue holds more than two tokens.
// Reset clears scan state and position and sets token_limit to 65535.
module arith_expression_lexer #(
   parameter int POS_BITS = 16
) (
   input  logic      clock,
   input  logic      reset,
   alx_req_if.sink   req_bus,
   alx_rsp_if.source rsp_bus,
   alx_csr_if.sink   csr_bus
);
   import alx_pkg::*;

   push_type  push;
   logic      room_ok;
   logic      pop;
   logic      head_valid;
   token_type head;

   alx_front #(
      .POS_BITS(POS_BITS)
   ) u_front (
      .clock   (clock),
      .reset   (reset),
      .req     (req_bus),
      .csr     (csr_bus),
      .room_ok (room_ok),
      .push    (push)
   );

   alx_tokq u_tokq (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .room_ok    (room_ok),
      .pop        (pop),
      .head_valid (head_valid),
      .head       (head)
   );

   alx_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop),
      .rsp        (rsp_bus)
   );

endmodule

// File: tb/sv/tb.sv
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import alx_pkg::*;

   localparam int POS_BITS = 16;
   localparam int IDLE_WAIT = 8;
   localparam int PHASE_BYTES = 275;

   logic clock = 1'b0;
   logic reset = 1'b1;

   always #10 clock = ~clock;

   alx_req_if req_bus();
   alx_rsp_if rsp_bus();
   alx_csr_if csr_bus();

   arith_expression_lexer #(.POS_BITS(POS_BITS)) dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   // scanner state mirrored from the block
   run_kind_type         scan_kind;
   logic [VALUE_W-1:0]   scan_value;
   logic                 scan_overflow;
   logic [POS_BITS-1:0]  scan_start;
   logic [POS_BITS-1:0]  byte_pos;
   logic [LIMIT_W-1:0]   token_count;
   logic [LIMIT_W-1:0]   token_limit_now;
   logic                 text_stopped;

   token_type            expected_tokens[$];
   logic [CH_W-1:0]      pending_bytes[$];

   logic                 req_fire = 1'b0;
   logic                 calm = 1'b0;
   int unsigned          send_gap = 0;
   int unsigned          take_gap = 0;
   int unsigned          mismatches = 0;
   int unsigned          token_index = 0;

   function automatic bit is_digit(logic [CH_W-1:0] c);
      return c >= CH_ZERO && c <= CH_NINE;
   endfunction

   function automatic bit is_id_start(logic [CH_W-1:0] c);
      return (c >= CH_LOWER_A && c <= CH_LOWER_Z) || (c >= CH_UPPER_A && c <= CH_UPPER_Z) ||
             c == CH_UNDERSCORE;
   endfunction

   function automatic void push_token(tok_kind_type kind, logic [VALUE_W-1:0] value,
                                      logic [POS_BITS-1:0] start,
                                      logic [POS_BITS-1:0] span, logic ovf);
      token_type t;
      if (text_stopped || token_count >= token_limit_now)
         return;
      token_count = token_count + 1'b1;
      t.kind = kind;
      t.value = value;
      t.start = TOK_W'(start);
      t.length = TOK_W'(span);
      t.overflow = ovf;
      t.last = (kind == KIND_EOF) || (token_count >= token_limit_now);
      if (t.last)
         text_stopped = 1'b1;
      expected_tokens.push_back(t);
   endfunction

   function automatic void close_run();
      logic [POS_BITS-1:0] span;
      span = byte_pos - scan_start;
      if (scan_kind == RUN_NUM)
         push_token(KIND_NUMBER, scan_value, scan_start, span, scan_overflow);
      else if (scan_kind == RUN_ID)
         push_token(KIND_IDENT, '0, scan_start, span, 1'b0);
      scan_kind = RUN_NONE;
      scan_value = '0;
      scan_overflow = 1'b0;
   endfunction

   function automatic void add_digit(logic [CH_W-1:0] c);
      logic [63:0] v;
      v = 64'(scan_value) * 64'd10 + 64'(c - CH_ZERO);
      if (scan_overflow || v > 64'(VALUE_MAX)) begin
         scan_value = VALUE_MAX;
         scan_overflow = 1'b1;
      end else begin
         scan_value = v[VALUE_W-1:0];
      end
   endfunction

   function automatic void lex_byte(logic [CH_W-1:0] c);
      tok_kind_type kind;
      if (c == CH_END) begin
         close_run();
         push_token(KIND_EOF, '0, byte_pos, '0, 1'b0);
         scan_start = '0;
         byte_pos = '0;
         token_count = '0;
         text_stopped = 1'b0;
         return;
      end
      if (scan_kind == RUN_NUM && is_digit(c)) begin
         add_digit(c);
      end else if (!(scan_kind == RUN_ID && (is_id_start(c) || is_digit(c)))) begin
         close_run();
         if (is_digit(c)) begin
            scan_kind = RUN_NUM;
            scan_start = byte_pos;
            scan_value = '0;
            scan_overflow = 1'b0;
            add_digit(c);
         end else if (is_id_start(c)) begin
            scan_kind = RUN_ID;
            scan_start = byte_pos;
         end else if (!(c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF)) begin
            case (c)
               CH_PLUS: begin
                  kind = KIND_PLUS;
               end
               CH_MINUS: begin
                  kind = KIND_MINUS;
               end
               CH_STAR: begin
                  kind = KIND_STAR;
               end
               CH_SLASH: begin
                  kind = KIND_SLASH;
               end
               CH_LPAREN: begin
                  kind = KIND_LPAREN;
               end
               CH_RPAREN: begin
                  kind = KIND_RPAREN;
               end
               default: begin
                  kind = KIND_UNKNOWN;
               end
            endcase
            push_token(kind, '0, byte_pos, POS_BITS'(1), 1'b0);
         end
      end
      byte_pos = byte_pos + 1'b1;
   endfunction

   task automatic report_mismatch(string what);
      $display("[%0t] token %0d: %s", $realtime, token_index, what);
      mismatches++;
   endtask

   task automatic check_field(string field, longint unsigned got, longint unsigned want);
      if (got != want)
         report_mismatch($sformatf("%s got %0h want %0h", field, got, want));
   endtask

   function automatic int unsigned pick_gap();
      int unsigned r;
      if (calm)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      if (r < 85)
         return $urandom_range(1, 3);
      if (r < 97)
         return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   task automatic push_string(string s);
      for (int i = 0; i < s.len(); i++)
         pending_bytes.push_back(s[i]);
   endtask

   // one random expression text, mostly well formed with some stray bytes
   function automatic int unsigned add_text();
      string id_chars = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
      string op_chars = "+-*/()";
      string blanks = " \t\r\n";
      int unsigned pieces;
      int unsigned len;
      int unsigned sel;
      int unsigned added;
      added = 0;
      pieces = $urandom_range(1, 12);
      repeat (pieces) begin
         sel = $urandom_range(0, 99);
         if (sel < 35) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 13) : $urandom_range(1, 4);
            repeat (len)
               pending_bytes.push_back(CH_W'(CH_ZERO + $urandom_range(0, 9)));
            added += len;
         end else if (sel < 55) begin
            len = $urandom_range(0, 5);
            pending_bytes.push_back(id_chars[$urandom_range(0, 52)]);
            repeat (len)
               pending_bytes.push_back(id_chars[$urandom_range(0, 62)]);
            added += len + 1;
         end else if (sel < 85) begin
            pending_bytes.push_back(op_chars[$urandom_range(0, 5)]);
            added++;
         end else if (sel < 93) begin
            pending_bytes.push_back(blanks[$urandom_range(0, 3)]);
            added++;
         end else begin
            pending_bytes.push_back(CH_W'($urandom_range(1, 255)));
            added++;
         end
         if ($urandom_range(0, 9) < 4) begin
            pending_bytes.push_back(blanks[$urandom_range(0, 3)]);
            added++;
         end
      end
      // leave some texts open so a limit change lands mid-text
      if ($urandom_range(0, 9) != 0) begin
         pending_bytes.push_back(CH_END);
         added++;
      end
      return added;
   endfunction

   always @(posedge clock) begin
      token_type want;
      if (reset) begin
         scan_kind = RUN_NONE;
         scan_value = '0;
         scan_overflow = 1'b0;
         scan_start = '0;
         byte_pos = '0;
         token_count = '0;
         token_limit_now = LIMIT_RESET;
         text_stopped = 1'b0;
         expected_tokens.delete();
         req_fire <= 1'b0;
      end else begin
         req_fire <= req_bus.valid && req_bus.ready;
         if (csr_bus.valid && csr_bus.ready)
            token_limit_now = csr_bus.token_limit;
         if (req_bus.valid && req_bus.ready)
            lex_byte(req_bus.ch);
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_tokens.size() == 0) begin
               report_mismatch($sformatf("kind %0d arrived with nothing pending",
                                         rsp_bus.tok_kind));
            end else begin
               want = expected_tokens.pop_front();
               check_field("kind", rsp_bus.tok_kind, want.kind);
               check_field("value", rsp_bus.tok_value, want.value);
               check_field("start", rsp_bus.tok_start, want.start);
               check_field("length", rsp_bus.tok_length, want.length);
               check_field("overflow", rsp_bus.value_overflow, want.overflow);
               check_field("last", rsp_bus.last, want.last);
            end
            token_index++;
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || req_fire) begin
         if (send_gap > 0) begin
            send_gap <= send_gap - 1;
            req_bus.valid <= 1'b0;
         end else if (pending_bytes.size() > 0) begin
            req_bus.ch <= pending_bytes.pop_front();
            req_bus.valid <= 1'b1;
            send_gap <= pick_gap();
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (take_gap > 0) begin
         take_gap <= take_gap - 1;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
         take_gap <= pick_gap();
      end
   end

   task automatic write_limit(logic [LIMIT_W-1:0] value);
      @(negedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.token_limit <= value;
      do @(posedge clock); while (!csr_bus.ready);
      @(negedge clock);
      csr_bus.valid <= 1'b0;
      @(posedge clock);
   endtask

   // hold until every byte is taken and every token has come back
   task automatic wait_idle();
      do @(negedge clock);
      while (pending_bytes.size() != 0 || req_bus.valid || expected_tokens.size() != 0);
      repeat (IDLE_WAIT) @(negedge clock);
   endtask

   initial begin
      logic [LIMIT_W-1:0] limits[6];
      int unsigned queued;
      req_bus.valid = 1'b0;
      req_bus.ch = '0;
      rsp_bus.ready = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.token_limit = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      push_string("9a_Z+-*/() \t\r\n");
      pending_bytes.push_back(8'hFF);
      pending_bytes.push_back(8'h80);
      push_string("2147483648");
      pending_bytes.push_back(CH_END);
      pending_bytes.push_back(CH_END);
      wait_idle();

      limits = '{16'd3, 16'd1, 16'd0, 16'd2, 16'd0, LIMIT_RESET};
      limits[4] = LIMIT_W'($urandom_range(4, 40));
      for (int k = 0; k < 6; k++) begin
         write_limit(limits[k]);
         calm = (k % 3 == 1);
         queued = 0;
         while (queued < PHASE_BYTES)
            queued += add_text();
         wait_idle();
      end
      calm = 1'b0;

      if (mismatches == 0 && expected_tokens.size() == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      #40_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
